// ----- rtl/core/lir_pkg.sv -----
// lir_pkg: shared constants and payload types of the linear interpolation resampler
// used by linear_interp_resampler and its port checker; no dependencies
package lir_pkg;

  localparam int FRAC_BITS   = 32;              // fraction bits of phase and step
  localparam int SAMPLE_W    = 16;              // sample width
  localparam int STEP_W      = 36;              // phase step register width
  localparam int PHASE_W     = 37;              // phase accumulator width
  localparam int MAX_RESULTS = 64;              // cap on results per input sample

  localparam int DIFF_W      = SAMPLE_W + 1;    // cur - prev
  localparam int ACC_W       = SAMPLE_W + 2;    // serial product accumulator
  localparam int BIT_CNT_W   = $clog2(FRAC_BITS);
  localparam int RUN_CNT_W   = $clog2(MAX_RESULTS);

  localparam logic [PHASE_W-1:0] ONE_PHASE = PHASE_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       last_of_run;
  } out_item_t;

endpackage

// ----- rtl/core/linear_interp_resampler.sv -----
// linear_interp_resampler: stereo sample rate converter by linear interpolation
// depends on lir_pkg for constants and the request payload types
//
// Each input request carries one stereo sample. The first sample after reset is
// only stored. For every later sample the block emits output requests while the
// 37-bit phase (32 fraction bits) is below one: out = prev + floor(phase *
// (cur - prev) / 2^32) on each channel, then phase += phase_step. Afterwards one
// is subtracted from the phase and the sample becomes prev; a sample that finds
// the phase already at or above one causes no output. At most 64 outputs follow
// one input; the last output of each run has last_of_run set. If the cap ends a
// run with the phase still below one, the phase restarts at zero instead. Each
// output passes through the bit-serial shift-add multiplier, one phase bit per
// cycle for both channels, and is then loaded into the output register; a
// finished result waits while the output register is full. A first or skipped
// sample is handled in S_IDLE alone, without the multiplier. in_ready is high
// whenever no run is in progress, even while the last output still waits in the
// output register.
// phase_step is written through phase_step_we / phase_step_data; the user must
// write it only while idle (unenforced). Reset one (1 << 32): no rate change.
module linear_interp_resampler
  import lir_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              phase_step_we,
  input  logic [STEP_W-1:0] phase_step_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,   // waiting for an input request
    S_MUL  = 3'b010,   // serial multiply, one phase bit per cycle
    S_EMIT = 3'b100    // result ready, waiting for a free output register
  } state_t;

  localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(FRAC_BITS - 1);
  localparam logic [RUN_CNT_W-1:0] RUN_LAST = RUN_CNT_W'(MAX_RESULTS - 1);

  state_t                     state;
  logic                       have_prev;
  logic [STEP_W-1:0]          phase_step;
  logic [PHASE_W-1:0]         phase;

  // sample registers
  logic signed [SAMPLE_W-1:0] prev_l, prev_r;
  logic signed [SAMPLE_W-1:0] cur_l, cur_r;
  logic signed [DIFF_W-1:0]   diff_l, diff_r;

  // serial multiplier: phase fraction shifts out lsb first
  logic [FRAC_BITS-1:0]       mult_sr;
  logic signed [ACC_W-1:0]    acc_l, acc_r;
  logic [BIT_CNT_W-1:0]       bit_cnt;
  logic [RUN_CNT_W-1:0]       run_cnt;

  logic signed [ACC_W-1:0]    sum_l, sum_r;
  logic signed [ACC_W-1:0]    acc_l_next, acc_r_next;
  logic signed [DIFF_W-1:0]   in_diff_l, in_diff_r;
  logic [PHASE_W-1:0]         phase_sum;
  logic                       phase_sum_ge_one;
  logic                       phase_is_frac;
  logic                       run_done;
  logic                       out_free;
  logic                       out_load;
  logic                       in_take;

  assign in_ready = (state == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == S_EMIT) && out_free;

  // difference of the new sample against the stored one, 17 bits
  assign in_diff_l = {in_data.left_in[SAMPLE_W-1], in_data.left_in}
                   - {prev_l[SAMPLE_W-1], prev_l};
  assign in_diff_r = {in_data.right_in[SAMPLE_W-1], in_data.right_in}
                   - {prev_r[SAMPLE_W-1], prev_r};

  // shift-add step: the arithmetic shift floors each partial division by two,
  // so after all fraction bits acc holds floor(phase * diff / 2^FRAC_BITS)
  assign sum_l = acc_l + (mult_sr[0] ? ACC_W'(diff_l) : '0);
  assign sum_r = acc_r + (mult_sr[0] ? ACC_W'(diff_r) : '0);
  assign acc_l_next = sum_l >>> 1;
  assign acc_r_next = sum_r >>> 1;

  // phase bookkeeping for the output being emitted
  assign phase_is_frac    = (phase[PHASE_W-1:FRAC_BITS] == '0);
  assign phase_sum        = phase + PHASE_W'(phase_step);
  assign phase_sum_ge_one = (phase_sum[PHASE_W-1:FRAC_BITS] != '0);
  assign run_done         = phase_sum_ge_one || (run_cnt == RUN_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      have_prev  <= 1'b0;
      phase      <= '0;
      phase_step <= ONE_PHASE[STEP_W-1:0];
      prev_l     <= '0;
      prev_r     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (phase_step_we) begin
        phase_step <= phase_step_data;
      end

      // output register: a new result takes priority over the drain
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (!have_prev) begin
              // first sample: only stored
              prev_l    <= in_data.left_in;
              prev_r    <= in_data.right_in;
              have_prev <= 1'b1;
            end else if (!phase_is_frac) begin
              // phase already past this interval: skip the sample
              phase  <= phase - ONE_PHASE;
              prev_l <= in_data.left_in;
              prev_r <= in_data.right_in;
            end else begin
              cur_l   <= in_data.left_in;
              cur_r   <= in_data.right_in;
              diff_l  <= in_diff_l;
              diff_r  <= in_diff_r;
              mult_sr <= phase[FRAC_BITS-1:0];
              acc_l   <= '0;
              acc_r   <= '0;
              bit_cnt <= '0;
              run_cnt <= '0;
              state   <= S_MUL;
            end
          end
        end

        S_MUL: begin
          acc_l   <= acc_l_next;
          acc_r   <= acc_r_next;
          mult_sr <= mult_sr >> 1;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BIT_LAST) begin
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_data.left_out     <= prev_l + acc_l[SAMPLE_W-1:0];
            out_data.right_out    <= prev_r + acc_r[SAMPLE_W-1:0];
            out_data.last_of_run  <= run_done;
            if (run_done) begin
              // end of run: step into the next interval, clamp at the cap
              phase  <= phase_sum_ge_one ? (phase_sum - ONE_PHASE) : '0;
              prev_l <= cur_l;
              prev_r <= cur_r;
              state  <= S_IDLE;
            end else begin
              phase   <= phase_sum;
              mult_sr <= phase_sum[FRAC_BITS-1:0];
              acc_l   <= '0;
              acc_r   <= '0;
              bit_cnt <= '0;
              run_cnt <= run_cnt + 1'b1;
              state   <= S_MUL;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/lir_checker.sv -----
// lir_checker: port-level assertions for linear_interp_resampler, bound to linear_interp_resampler
// depends on lir_pkg for the payload types
module lir_checker
  import lir_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled output request holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output request changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // a new output only appears while a run is in progress
  a_out_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("output appeared while block was idle");

  // an output never appears straight from idle with an empty output register
  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    in_ready && !out_valid |=> !$rose(out_valid))
    else $error("output appeared straight from idle");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
